@@ src/fcst_pkg.sv @@
// Package with request codes, outcome codes and status bit positions of the fault code table.
`timescale 1ns / 1ps
`default_nettype none
package fcst_pkg;

  localparam int unsigned TableDepthDefault = 32;

  typedef enum logic [3:0] {
    REQ_INSERT       = 4'd0,
    REQ_REMOVE       = 4'd1,
    REQ_FIND         = 4'd2,
    REQ_COUNT_CODE   = 4'd3,
    REQ_COUNT_STATUS = 4'd4,
    REQ_LIST_STATUS  = 4'd5,
    REQ_LIST_CONF    = 4'd6,
    REQ_LIST_PEND    = 4'd7,
    REQ_LIST_ACTIVE  = 4'd8,
    REQ_READ_INDEX   = 4'd9,
    REQ_DUMP         = 4'd10
  } req_t;

  typedef enum logic [1:0] {
    OUT_OK        = 2'd0,
    OUT_DUPLICATE = 2'd1,
    OUT_NOT_FOUND = 2'd2,
    OUT_FULL      = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT
  } state_t;

  localparam int unsigned BitFailed    = 0;
  localparam int unsigned BitPending   = 2;
  localparam int unsigned BitConfirmed = 3;

endpackage
`default_nettype wire

@@ src/fault_code_sorted_table.sv @@
// Top level of the sorted fault code table with its sequencer and entry memory.
`timescale 1ns / 1ps
`default_nettype none
// A request is taken whenever the block is idle. Every find, remove, insert, count or list
// walks the table one entry per cycle through a single read port of the entry memory and one
// shared compare unit, but a list pauses when a newly selected entry arrives while the previous
// one cannot yet be emitted. An insert or remove then moves each entry above its position,
// reading it and writing it back, and an insert finally writes the new entry at its position.
// Each result is held in an output register until it is taken; a list waits there per emitted
// beat, and the next request may be accepted while the final beat of the previous one waits.
module fault_code_sorted_table #(
  parameter int unsigned TABLE_DEPTH = fcst_pkg::TableDepthDefault
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [3:0]  req_type,
  input  wire  [23:0] key_code,
  input  wire  [7:0]  status_value,
  input  wire  [7:0]  bit_mask,
  input  wire  [5:0]  slot_index,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  outcome,
  output logic [23:0] entry_code,
  output logic [7:0]  entry_status,
  output logic [1:0]  severity,
  output logic        confirmed_flag,
  output logic        pending_flag,
  output logic [6:0]  match_count,
  output logic        last
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  logic [31:0] mem [TABLE_DEPTH];

  fcst_pkg::state_t state, state_next;
  logic [3:0]  kind;
  logic [23:0] key;
  logic [7:0]  sv;
  logic [7:0]  mask;
  logic [5:0]  slot;
  logic [CW-1:0] fill;
  logic [CW-1:0] idx;      // Index of the entry being read.
  logic          rd_v;     // Read data valid for entry at rd_idx.
  logic [CW-1:0] rd_idx;
  logic [31:0]   rd_data;
  logic [6:0]    cnt;
  logic [CW-1:0] pos;      // Insert position or remove position.
  logic          found;
  logic          pend_v;   // A selected entry waits to be emitted.
  logic [31:0]   pend;
  logic [CW-1:0] sh;       // Shift cursor.
  logic          sh_rd;    // Shift read in flight.

  logic is_list;
  logic sel;
  logic list_hold;
  logic [7:0] rst_st;

  always_comb begin
    is_list = (kind == fcst_pkg::REQ_LIST_STATUS) || (kind == fcst_pkg::REQ_LIST_CONF) ||
              (kind == fcst_pkg::REQ_LIST_PEND) || (kind == fcst_pkg::REQ_LIST_ACTIVE) ||
              (kind == fcst_pkg::REQ_DUMP);
    rst_st = rd_data[7:0];
    case (kind)
      fcst_pkg::REQ_LIST_STATUS: sel = (rst_st == sv);
      fcst_pkg::REQ_LIST_CONF:   sel = rst_st[fcst_pkg::BitFailed] &
                                       rst_st[fcst_pkg::BitConfirmed];
      fcst_pkg::REQ_LIST_PEND:   sel = rst_st[fcst_pkg::BitPending] &
                                       ~rst_st[fcst_pkg::BitConfirmed];
      fcst_pkg::REQ_LIST_ACTIVE: sel = rst_st[fcst_pkg::BitFailed];
      default:                   sel = 1'b1;
    endcase
  end

  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == fcst_pkg::ST_IDLE);
  // A newly read entry is selected while the previous one cannot yet be emitted.
  assign list_hold = is_list && rd_v && sel && pend_v && !out_free;

  // Result register load.
  logic        o_load;
  logic [1:0]  o_outc;
  logic        o_has;
  logic [31:0] o_ent;
  logic [6:0]  o_cnt;
  logic        o_last;
  logic        done;
  logic        go_shift;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0] mem_wd;
  logic        rd_en;
  logic [AW-1:0] rd_a;

  always_comb begin
    o_load = 1'b0; o_outc = fcst_pkg::OUT_OK; o_has = 1'b0; o_ent = '0; o_cnt = '0;
    o_last = 1'b1; done = 1'b0; go_shift = 1'b0;
    mem_we = 1'b0; mem_wa = '0; mem_wd = '0; rd_en = 1'b0; rd_a = '0;
    if (state == fcst_pkg::ST_SCAN) begin
      rd_en = (idx < fill);
      rd_a = AW'(idx);
      if (kind == fcst_pkg::REQ_READ_INDEX) begin
        rd_a = AW'(slot);
        if ({1'b0, slot} >= 7'(fill)) begin
          if (out_free) begin
            o_load = 1'b1; o_outc = fcst_pkg::OUT_NOT_FOUND; done = 1'b1;
          end
        end else if (rd_v && out_free) begin
          o_load = 1'b1; o_has = 1'b1; o_ent = rd_data; done = 1'b1;
        end
        rd_en = 1'b1;
      end else if (is_list) begin
        rd_en = (idx < fill) && !list_hold;
        if (!rd_v && !rd_en && out_free) begin
          o_load = 1'b1; done = 1'b1;
          if (pend_v) begin
            o_has = 1'b1; o_ent = pend;
          end else begin
            o_outc = fcst_pkg::OUT_NOT_FOUND;
          end
        end else if (rd_v && sel && pend_v && out_free) begin
          o_load = 1'b1; o_has = 1'b1; o_ent = pend; o_last = 1'b0;
        end
      end else if (!rd_v && idx >= fill) begin
        if (out_free) begin
          o_load = 1'b1; done = 1'b1;
          case (kind)
            fcst_pkg::REQ_COUNT_CODE, fcst_pkg::REQ_COUNT_STATUS: o_cnt = cnt;
            fcst_pkg::REQ_INSERT: begin
              if (found) o_outc = fcst_pkg::OUT_DUPLICATE;
              else if (fill >= DepthC) o_outc = fcst_pkg::OUT_FULL;
              else begin
                o_has = 1'b1; o_ent = {key, sv}; done = 1'b0; go_shift = 1'b1;
              end
            end
            fcst_pkg::REQ_REMOVE: begin
              if (!found) o_outc = fcst_pkg::OUT_NOT_FOUND;
              else begin
                o_has = 1'b1; o_ent = pend; done = 1'b0; go_shift = 1'b1;
              end
            end
            default: begin
              if (!found) o_outc = fcst_pkg::OUT_NOT_FOUND;
              else begin
                o_has = 1'b1; o_ent = pend;
              end
            end
          endcase
        end
      end
    end else if (state == fcst_pkg::ST_SHIFT) begin
      if (kind == fcst_pkg::REQ_INSERT) begin
        // Move entries up from the top down to pos, then write the new entry.
        if (sh_rd) begin
          mem_we = 1'b1; mem_wa = AW'(sh); mem_wd = rd_data;
        end else if (sh == pos) begin
          mem_we = 1'b1; mem_wa = AW'(pos); mem_wd = {key, sv}; done = 1'b1;
        end else begin
          rd_en = 1'b1; rd_a = AW'(sh - CW'(1));
        end
      end else begin
        if (sh_rd) begin
          mem_we = 1'b1; mem_wa = AW'(sh - CW'(1)); mem_wd = rd_data;
        end else if (sh >= fill) begin
          done = 1'b1;
        end else begin
          rd_en = 1'b1; rd_a = AW'(sh);
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fcst_pkg::ST_IDLE: if (in_valid && in_ready) begin
        state_next = (req_type > 4'(fcst_pkg::REQ_DUMP)) ? fcst_pkg::ST_IDLE
                                                          : fcst_pkg::ST_SCAN;
      end
      fcst_pkg::ST_SCAN: begin
        if (go_shift) state_next = fcst_pkg::ST_SHIFT;
        else if (done) state_next = fcst_pkg::ST_IDLE;
      end
      fcst_pkg::ST_SHIFT: if (done) begin
        state_next = fcst_pkg::ST_IDLE;
      end
      default:            state_next = fcst_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en) rd_data <= mem[rd_a];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcst_pkg::ST_IDLE;
      fill <= '0;
      out_valid <= 1'b0;
      rd_v <= 1'b0;
      sh_rd <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (o_load) begin
        out_valid <= 1'b1;
        outcome <= o_outc;
        entry_code <= o_has ? o_ent[31:8] : 24'd0;
        entry_status <= o_has ? o_ent[7:0] : 8'd0;
        severity <= o_has ? o_ent[31:30] : 2'd0;
        confirmed_flag <= o_has & o_ent[fcst_pkg::BitFailed] & o_ent[fcst_pkg::BitConfirmed];
        pending_flag <= o_has & o_ent[fcst_pkg::BitPending] & ~o_ent[fcst_pkg::BitConfirmed];
        match_count <= o_cnt;
        last <= o_last;
      end
      case (state)
        fcst_pkg::ST_IDLE: begin
          kind <= req_type; key <= key_code; sv <= status_value; mask <= bit_mask;
          slot <= slot_index;
          idx <= '0; cnt <= '0; pos <= fill; found <= 1'b0; pend_v <= 1'b0;
          rd_v <= 1'b0;
        end
        fcst_pkg::ST_SCAN: begin
          if (!list_hold) begin
            rd_v <= rd_en;
            rd_idx <= idx;
          end
          if (rd_en && kind != fcst_pkg::REQ_READ_INDEX) idx <= idx + CW'(1);
          if (rd_v && !list_hold) begin
            case (kind)
              fcst_pkg::REQ_COUNT_CODE:
                if ((rd_data[15:8] & mask) != 8'd0) cnt <= cnt + 7'd1;
              fcst_pkg::REQ_COUNT_STATUS:
                if ((rd_data[7:0] & mask) != 8'd0) cnt <= cnt + 7'd1;
              fcst_pkg::REQ_READ_INDEX: ;
              default: begin
                if (is_list) begin
                  if (sel) begin
                    pend <= rd_data; pend_v <= 1'b1;
                  end
                end else begin
                  if (rd_data[31:8] == key) begin
                    found <= 1'b1; pend <= rd_data; pos <= rd_idx;
                  end else if (rd_data[31:8] > key && rd_idx < pos &&
                               kind == fcst_pkg::REQ_INSERT) begin
                    pos <= rd_idx;
                  end
                end
              end
            endcase
          end
          if (go_shift) begin
            sh_rd <= 1'b0;
            sh <= (kind == fcst_pkg::REQ_INSERT) ? fill : pos + CW'(1);
          end
        end
        fcst_pkg::ST_SHIFT: begin
          sh_rd <= rd_en;
          if (kind == fcst_pkg::REQ_INSERT) begin
            if (sh_rd) sh <= sh - CW'(1);
          end else if (sh_rd) begin
            sh <= sh + CW'(1);
          end
          if (done) begin
            fill <= (kind == fcst_pkg::REQ_INSERT) ? fill + CW'(1) : fill - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/fault_code_sorted_table_tb.sv @@
// Self-checking testbench for the sorted fault code table with random stimulus and idling.
`timescale 1ns / 1ps
`default_nettype none
module fault_code_sorted_table_tb;

  localparam int Depth = int'(fcst_pkg::TableDepthDefault);

  typedef struct packed {
    logic [3:0]  kind;
    logic [23:0] code;
    logic [7:0]  stat;
    logic [7:0]  mask;
    logic [5:0]  slot;
  } request_t;

  typedef struct packed {
    logic [1:0]  outc;
    logic [23:0] code;
    logic [7:0]  stat;
    logic [1:0]  sev;
    logic        conf;
    logic        pend;
    logic [6:0]  cnt;
    logic        fin;
  } entry_beat_t;

  typedef struct {
    request_t req;
    logic     has_exp;
    logic [1:0] outc;
    logic [6:0] cnt;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] req_type = '0;
  logic [23:0] key_code = '0;
  logic [7:0] status_value = '0;
  logic [7:0] bit_mask = '0;
  logic [5:0] slot_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] outcome;
  logic [23:0] entry_code;
  logic [7:0] entry_status;
  logic [1:0] severity;
  logic confirmed_flag;
  logic pending_flag;
  logic [6:0] match_count;
  logic last;

  fault_code_sorted_table dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .key_code(key_code), .status_value(status_value),
    .bit_mask(bit_mask), .slot_index(slot_index), .out_valid(out_valid),
    .out_ready(out_ready), .outcome(outcome), .entry_code(entry_code),
    .entry_status(entry_status), .severity(severity), .confirmed_flag(confirmed_flag),
    .pending_flag(pending_flag), .match_count(match_count), .last(last)
  );

  logic [23:0] tbl_code [Depth];
  logic [7:0]  tbl_stat [Depth];
  int          tbl_fill;
  entry_beat_t expected_beats[$];
  int errors = 0;
  int beats_seen = 0;
  int items_sent = 0;
  int send_idle = 0;
  int recv_stall = 0;
  logic hold_go = 1'b0;
  logic hold_active = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  // The receiver holds off for a long stretch once the main sequence asks for it.
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (400) @(posedge clk);
    hold_active <= 1'b0;
  end

  function automatic entry_beat_t make_beat(int oc, int has, int c, int s, int n, int f);
    entry_beat_t b;
    logic [23:0] code;
    logic [7:0]  stat;
    code = (has != 0) ? 24'(c) : 24'd0;
    stat = (has != 0) ? 8'(s) : 8'd0;
    b.outc = 2'(oc);
    b.code = code;
    b.stat = stat;
    b.sev = code[23:22];
    b.conf = stat[fcst_pkg::BitFailed] & stat[fcst_pkg::BitConfirmed];
    b.pend = stat[fcst_pkg::BitPending] & ~stat[fcst_pkg::BitConfirmed];
    b.cnt = 7'(n);
    b.fin = (f != 0);
    return b;
  endfunction

  function automatic entry_beat_t none_beat(int oc);
    return make_beat(oc, 0, 0, 0, 0, 1);
  endfunction

  task automatic queue_beat(entry_beat_t b);
    expected_beats.insert(expected_beats.size(), b);
  endtask

  function automatic logic picks(logic [3:0] k, logic [7:0] s, logic [7:0] want);
    case (k)
      fcst_pkg::REQ_LIST_STATUS: return s == want;
      fcst_pkg::REQ_LIST_CONF:   return s[fcst_pkg::BitFailed] & s[fcst_pkg::BitConfirmed];
      fcst_pkg::REQ_LIST_PEND:   return s[fcst_pkg::BitPending] & ~s[fcst_pkg::BitConfirmed];
      fcst_pkg::REQ_LIST_ACTIVE: return s[fcst_pkg::BitFailed];
      default:                   return 1'b1;
    endcase
  endfunction

  // Updates the table copy and queues the beats one request yields.
  task automatic predict_table(request_t r);
    int pos, n, lastpos;
    pos = tbl_fill;
    for (int i = 0; i < tbl_fill; i++) if (tbl_code[i] == r.code && pos == tbl_fill) pos = i;
    case (r.kind)
      fcst_pkg::REQ_INSERT: begin
        if (pos < tbl_fill) queue_beat(none_beat(fcst_pkg::OUT_DUPLICATE));
        else if (tbl_fill >= Depth) queue_beat(none_beat(fcst_pkg::OUT_FULL));
        else begin
          pos = 0;
          while (pos < tbl_fill && tbl_code[pos] < r.code) pos++;
          for (int i = tbl_fill; i > pos; i--) begin
            tbl_code[i] = tbl_code[i-1];
            tbl_stat[i] = tbl_stat[i-1];
          end
          tbl_code[pos] = r.code;
          tbl_stat[pos] = r.stat;
          tbl_fill++;
          queue_beat(make_beat(fcst_pkg::OUT_OK, 1, int'(r.code), int'(r.stat), 0, 1));
        end
      end
      fcst_pkg::REQ_REMOVE: begin
        if (pos >= tbl_fill) queue_beat(none_beat(fcst_pkg::OUT_NOT_FOUND));
        else begin
          queue_beat(make_beat(fcst_pkg::OUT_OK, 1, int'(tbl_code[pos]), int'(tbl_stat[pos]),
                               0, 1));
          for (int i = pos; i + 1 < tbl_fill; i++) begin
            tbl_code[i] = tbl_code[i+1];
            tbl_stat[i] = tbl_stat[i+1];
          end
          tbl_fill--;
        end
      end
      fcst_pkg::REQ_FIND: begin
        if (pos >= tbl_fill) queue_beat(none_beat(fcst_pkg::OUT_NOT_FOUND));
        else queue_beat(make_beat(fcst_pkg::OUT_OK, 1, int'(tbl_code[pos]),
                                  int'(tbl_stat[pos]), 0, 1));
      end
      fcst_pkg::REQ_COUNT_CODE, fcst_pkg::REQ_COUNT_STATUS: begin
        n = 0;
        for (int i = 0; i < tbl_fill; i++)
          if (((r.kind == fcst_pkg::REQ_COUNT_CODE ? tbl_code[i][7:0] : tbl_stat[i]) &
               r.mask) != 0) n++;
        queue_beat(make_beat(fcst_pkg::OUT_OK, 0, 0, 0, n, 1));
      end
      fcst_pkg::REQ_READ_INDEX: begin
        if (r.slot >= tbl_fill) queue_beat(none_beat(fcst_pkg::OUT_NOT_FOUND));
        else queue_beat(make_beat(fcst_pkg::OUT_OK, 1, int'(tbl_code[r.slot]),
                                  int'(tbl_stat[r.slot]), 0, 1));
      end
      fcst_pkg::REQ_LIST_STATUS, fcst_pkg::REQ_LIST_CONF, fcst_pkg::REQ_LIST_PEND,
      fcst_pkg::REQ_LIST_ACTIVE, fcst_pkg::REQ_DUMP: begin
        lastpos = -1;
        for (int i = 0; i < tbl_fill; i++) if (picks(r.kind, tbl_stat[i], r.stat)) lastpos = i;
        for (int i = 0; i < tbl_fill; i++)
          if (picks(r.kind, tbl_stat[i], r.stat))
            queue_beat(make_beat(fcst_pkg::OUT_OK, 1, int'(tbl_code[i]), int'(tbl_stat[i]), 0,
                                 int'(i == lastpos)));
        if (lastpos < 0) queue_beat(none_beat(fcst_pkg::OUT_NOT_FOUND));
      end
      default: ;
    endcase
  endtask

  // Receiver side: stalls at random and checks every accepted beat.
  always @(posedge clk) begin
    entry_beat_t got, want;
    if (!rst && out_valid && out_ready) begin
      beats_seen++;
      got = '{outcome, entry_code, entry_status, severity, confirmed_flag, pending_flag,
              match_count, last};
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat %h", got);
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %h actual %h", want, got);
        end
      end
    end
    if (hold_active) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic send_request(request_t r);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    req_type <= r.kind;
    key_code <= r.code;
    status_value <= r.stat;
    bit_mask <= r.mask;
    slot_index <= r.slot;
    do @(posedge clk); while (!in_ready);
    predict_table(r);
    items_sent++;
  endtask

  function automatic request_t random_request();
    request_t r;
    int pick;
    r.code = 24'($urandom());
    if ($urandom_range(3) != 0 && tbl_fill > 0) r.code = tbl_code[$urandom_range(tbl_fill - 1)];
    else if ($urandom_range(1) == 0) r.code = {r.code[23:22], 14'd0, r.code[7:0]};
    r.stat = 8'($urandom());
    if ($urandom_range(2) == 0 && tbl_fill > 0) r.stat = tbl_stat[$urandom_range(tbl_fill - 1)];
    r.mask = 8'($urandom());
    r.slot = 6'($urandom());
    if ($urandom_range(1) == 0) r.slot = 6'($urandom_range(Depth));
    pick = $urandom_range(99);
    if (pick < 40) r.kind = fcst_pkg::REQ_INSERT;
    else if (pick < 52) r.kind = fcst_pkg::REQ_REMOVE;
    else if (pick < 96) r.kind = 4'($urandom_range(fcst_pkg::REQ_FIND, fcst_pkg::REQ_DUMP));
    else r.kind = 4'($urandom_range(11, 15));
    return r;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  row_t rows[$];

  task automatic add_row(int k, int c, int s, int m, int sl, int he, int oc, int n);
    row_t w;
    w.req.kind = 4'(k);
    w.req.code = 24'(c);
    w.req.stat = 8'(s);
    w.req.mask = 8'(m);
    w.req.slot = 6'(sl);
    w.has_exp = (he != 0);
    w.outc = 2'(oc);
    w.cnt = 7'(n);
    rows.insert(rows.size(), w);
  endtask

  initial begin
    request_t r;
    tbl_fill = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // Empty table, extremes, every request kind and the duplicate case.
    add_row(fcst_pkg::REQ_DUMP, 0, 0, 0, 0, 1, fcst_pkg::OUT_NOT_FOUND, 0);
    add_row(fcst_pkg::REQ_FIND, 24'hFFFFFF, 0, 0, 0, 1, fcst_pkg::OUT_NOT_FOUND, 0);
    add_row(fcst_pkg::REQ_REMOVE, 0, 0, 0, 0, 1, fcst_pkg::OUT_NOT_FOUND, 0);
    add_row(fcst_pkg::REQ_READ_INDEX, 0, 0, 0, 0, 1, fcst_pkg::OUT_NOT_FOUND, 0);
    add_row(fcst_pkg::REQ_COUNT_CODE, 0, 0, 8'hFF, 0, 1, fcst_pkg::OUT_OK, 0);
    add_row(fcst_pkg::REQ_INSERT, 24'hFFFFFF, 8'hFF, 0, 0, 0, 0, 0);
    add_row(fcst_pkg::REQ_INSERT, 24'h000000, 8'h00, 0, 0, 0, 0, 0);
    add_row(fcst_pkg::REQ_INSERT, 24'h400012, 8'h05, 0, 0, 0, 0, 0);
    add_row(fcst_pkg::REQ_INSERT, 24'h800034, 8'h09, 0, 0, 0, 0, 0);
    add_row(fcst_pkg::REQ_INSERT, 24'h400012, 8'h01, 0, 0, 1, fcst_pkg::OUT_DUPLICATE, 0);
    add_row(fcst_pkg::REQ_FIND, 24'h800034, 0, 0, 0, 0, 0, 0);
    add_row(fcst_pkg::REQ_COUNT_CODE, 0, 0, 8'h10, 0, 0, 0, 0);
    add_row(fcst_pkg::REQ_COUNT_STATUS, 0, 0, 8'h01, 0, 0, 0, 0);
    add_row(fcst_pkg::REQ_LIST_STATUS, 0, 8'h05, 0, 0, 0, 0, 0);
    add_row(fcst_pkg::REQ_LIST_CONF, 0, 0, 0, 0, 0, 0, 0);
    add_row(fcst_pkg::REQ_LIST_PEND, 0, 0, 0, 0, 0, 0, 0);
    add_row(fcst_pkg::REQ_LIST_ACTIVE, 0, 0, 0, 0, 0, 0, 0);
    add_row(fcst_pkg::REQ_READ_INDEX, 0, 0, 0, 63, 1, fcst_pkg::OUT_NOT_FOUND, 0);
    add_row(fcst_pkg::REQ_READ_INDEX, 0, 0, 0, 3, 0, 0, 0);
    add_row(15, 24'hABCDEF, 0, 0, 0, 0, 0, 0);
    add_row(fcst_pkg::REQ_REMOVE, 24'h000000, 0, 0, 0, 0, 0, 0);
    add_row(fcst_pkg::REQ_DUMP, 0, 0, 0, 0, 0, 0, 0);
    foreach (rows[i]) begin
      if (rows[i].has_exp) begin
        entry_beat_t b;
        b = make_beat(int'(rows[i].outc), 0, 0, 0, int'(rows[i].cnt), 1);
        send_request(rows[i].req);
        if (expected_beats[$] !== b) begin
          errors++;
          $display("directed row %0d predictor disagrees with table", i);
        end
      end else send_request(rows[i].req);
    end
    // Fill to capacity, starting with the receiver held off, then try one more insert.
    hold_go = 1'b1;
    while (tbl_fill < Depth) begin
      r = random_request();
      r.kind = fcst_pkg::REQ_INSERT;
      r.code = 24'($urandom());
      send_request(r);
    end
    r.kind = fcst_pkg::REQ_INSERT;
    r.code = 24'h123456;
    send_request(r);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? 80 : 0;
      recv_stall = (ph == 2) ? 80 : (ph == 3 ? 6 : 0);
      if (ph == 3) send_idle = 6;
      for (int k = 0; k < 60; k++) send_request(random_request());
      drain();
    end
    $display("covered %0d requests and %0d result beats over idle and stall phases",
             items_sent, beats_seen);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
src/fcst_pkg.sv
src/fault_code_sorted_table.sv
tb/sv/fault_code_sorted_table_tb.sv
